FILE: rtl/fpdl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fpdl_pkg;

	// Field and register widths
	localparam int DATA_W  = 16;
	localparam int IDX_W   = 10;
	localparam int CFG_W   = 11;
	localparam int CIDX_W  = 2;
	localparam int PROD_W  = 2 * DATA_W;

	// Q8 weights: products scale down by 2**Q_SHIFT
	localparam int Q_SHIFT = 8;

	// Upper bound of both layer lengths
	localparam int LEN_LIMIT = 1024;

	typedef enum logic [0:0] {
		OP_LOAD   = 1'b0,
		OP_WEIGHT = 1'b1
	} op_t;

	typedef enum logic [CIDX_W-1:0] {
		REG_INPUT_LEN  = 2'd0,
		REG_OUTPUT_LEN = 2'd1,
		REG_RELU       = 2'd2
	} reg_idx_t;

	// Per-weight bookkeeping that travels with the store read
	typedef struct packed {
		logic             end_row;
		logic             last_neuron;
		logic             relu;
		logic [IDX_W-1:0] row_idx;
	} tag_t;

endpackage

`default_nettype wire

FILE: rtl/fpdl_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module fpdl_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port, holds while not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/fpdl_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module fpdl_ctrl import fpdl_pkg::*; #(
	parameter int MAX_INPUTS = 1024
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          accept,
	input  wire logic                          operation,
	input  wire logic [IDX_W-1:0]              element_index,
	input  wire logic [DATA_W-1:0]             data_value,
	input  wire logic                          cfg_we,
	input  wire logic [CIDX_W-1:0]             cfg_index,
	input  wire logic [CFG_W-1:0]              cfg_data,
	output      logic                          mem_we,
	output      logic [$clog2(MAX_INPUTS)-1:0] mem_waddr,
	output      logic [DATA_W-1:0]             mem_wdata,
	output      logic                          mem_re,
	output      logic [$clog2(MAX_INPUTS)-1:0] mem_raddr,
	output      tag_t                          tag
);

	localparam int AW    = $clog2(MAX_INPUTS);
	localparam int CAP_I = (LEN_LIMIT < MAX_INPUTS) ? LEN_LIMIT : MAX_INPUTS;
	localparam logic [CFG_W-1:0] ILEN_CAP = CFG_W'(CAP_I);
	localparam logic [CFG_W-1:0] OLEN_CAP = CFG_W'(LEN_LIMIT);
	localparam logic [CFG_W-1:0] LEN_ONE  = CFG_W'(1);

	logic [CFG_W-1:0] in_len_q;
	logic [CFG_W-1:0] out_len_q;
	logic             relu_q;
	logic [IDX_W-1:0] wpos_q;
	logic [IDX_W-1:0] row_q;

	logic [CFG_W-1:0] ilen;
	logic [CFG_W-1:0] olen;
	logic [CFG_W-1:0] wpos_inc;
	logic [CFG_W-1:0] row_inc;
	logic [IDX_W-1:0] rpos;
	logic             end_row;
	logic             last_row;
	logic             load_ok;
	logic             is_weight;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_len_q  <= LEN_ONE;
			out_len_q <= LEN_ONE;
			relu_q    <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_INPUT_LEN:  in_len_q  <= cfg_data;
				REG_OUTPUT_LEN: out_len_q <= cfg_data;
				REG_RELU:       relu_q    <= cfg_data[0];
				default:        ;
			endcase
		end
	end

	// Saturate lengths into their legal ranges
	always_comb begin
		if (in_len_q == '0) begin
			ilen = LEN_ONE;
		end else if (in_len_q > ILEN_CAP) begin
			ilen = ILEN_CAP;
		end else begin
			ilen = in_len_q;
		end
		if (out_len_q == '0) begin
			olen = LEN_ONE;
		end else if (out_len_q > OLEN_CAP) begin
			olen = OLEN_CAP;
		end else begin
			olen = out_len_q;
		end
	end

	// Position, row end and layer end for the current weight
	always_comb begin
		wpos_inc = {1'b0, wpos_q} + LEN_ONE;
		row_inc  = {1'b0, row_q} + LEN_ONE;
		end_row  = !(wpos_inc < ilen);
		last_row = (row_inc >= olen);
		rpos     = ({1'b0, wpos_q} < ilen) ? wpos_q : IDX_W'(ilen - LEN_ONE);
	end

	assign is_weight = accept && (operation == OP_WEIGHT);
	assign load_ok   = 32'(element_index) < 32'(MAX_INPUTS);

	// Store port requests
	assign mem_we    = accept && (operation == OP_LOAD) && load_ok;
	assign mem_waddr = AW'(element_index);
	assign mem_wdata = data_value;
	assign mem_re    = is_weight;
	assign mem_raddr = AW'(rpos);

	assign tag.end_row     = end_row;
	assign tag.last_neuron = last_row;
	assign tag.relu        = relu_q;
	assign tag.row_idx     = row_q;

	// Advance weight position and row counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wpos_q <= '0;
			row_q  <= '0;
		end else if (is_weight) begin
			if (end_row) begin
				wpos_q <= '0;
				row_q  <= last_row ? '0 : row_inc[IDX_W-1:0];
			end else begin
				wpos_q <= wpos_inc[IDX_W-1:0];
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/fpdl_mac.sv
`timescale 1ns / 1ps
`default_nettype none

module fpdl_mac import fpdl_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     issue,
	input  wire tag_t                     tag,
	input  wire logic signed [DATA_W-1:0] weight,
	input  wire logic signed [DATA_W-1:0] bias,
	input  wire logic signed [DATA_W-1:0] rdata,
	input  wire logic                     result_stall,
	output      logic                     hold,
	output      logic                     result_valid,
	output      logic signed [DATA_W-1:0] neuron_value,
	output      logic [IDX_W-1:0]         neuron_index,
	output      logic                     last_neuron
);

	logic                     adv;

	logic                     vld_s1;
	tag_t                     tag_s1;
	logic signed [DATA_W-1:0] wgt_s1;
	logic signed [DATA_W-1:0] bias_s1;

	logic                     vld_s2;
	tag_t                     tag_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [DATA_W-1:0] bias_s2;

	logic [DATA_W-1:0]        acc_q;

	logic [PROD_W-1:0]        adj;
	logic [DATA_W-1:0]        quot;
	logic [DATA_W-1:0]        acc_next;
	logic [DATA_W-1:0]        sum;

	// Freeze the pipeline while a result waits on a stalled output
	assign hold = result_valid && result_stall;
	assign adv  = !hold;

	// Stage 1: store read in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			tag_s1  <= tag;
			wgt_s1  <= weight;
			bias_s1 <= bias;
		end
	end

	// Stage 2: multiply stored element by weight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && vld_s1) begin
			tag_s2  <= tag_s1;
			prod_s2 <= rdata * wgt_s1;
			bias_s2 <= bias_s1;
		end
	end

	// Divide by 2**Q_SHIFT toward zero, accumulate, add bias, clamp
	always_comb begin
		adj      = prod_s2 + PROD_W'({Q_SHIFT{prod_s2[PROD_W-1]}});
		quot     = adj[Q_SHIFT +: DATA_W];
		acc_next = acc_q + quot;
		sum      = acc_next + bias_s2;
		if (tag_s2.relu && sum[DATA_W-1]) begin
			sum = '0;
		end
	end

	// Row accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (adv && vld_s2) begin
			acc_q <= tag_s2.end_row ? '0 : acc_next;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (adv) begin
			result_valid <= vld_s2 && tag_s2.end_row;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && vld_s2 && tag_s2.end_row) begin
			neuron_value <= sum;
			neuron_index <= tag_s2.row_idx;
			last_neuron  <= tag_s2.last_neuron;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/fixed_point_dense_layer_core.sv
// Channel   Handshake                  Payload
// request   item_valid / item_stall    operation, element_index, data_value, bias_value
// result    result_valid / result_stall neuron_value, neuron_index, last_neuron
//
// One request per cycle unless stalled; row results leave via stage 1, stage 2, output reg.
// Loads write the input store through its write port; weights read it through the read port.
// Reset is asynchronous and active low; the input store keeps no reset and holds garbage
// until loaded.
// item_stall rises only while a result sits in the output register under result_stall;
// the whole pipeline then freezes.
`timescale 1ns / 1ps
`default_nettype none

module fixed_point_dense_layer_core import fpdl_pkg::*; #(
	parameter int MAX_INPUTS = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     item_valid,
	output      logic                     item_stall,
	input  wire logic                     operation,
	input  wire logic [IDX_W-1:0]         element_index,
	input  wire logic signed [DATA_W-1:0] data_value,
	input  wire logic signed [DATA_W-1:0] bias_value,
	output      logic                     result_valid,
	input  wire logic                     result_stall,
	output      logic signed [DATA_W-1:0] neuron_value,
	output      logic [IDX_W-1:0]         neuron_index,
	output      logic                     last_neuron,
	input  wire logic                     cfg_we,
	input  wire logic [CIDX_W-1:0]        cfg_index,
	input  wire logic [CFG_W-1:0]         cfg_data
);

	localparam int AW = $clog2(MAX_INPUTS);

	logic              hold;
	logic              accept;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [DATA_W-1:0] mem_wdata;
	logic              mem_re;
	logic [AW-1:0]     mem_raddr;
	logic [DATA_W-1:0] mem_rdata;
	tag_t              tag;

	// Take a request whenever the output side is not blocked
	assign item_stall = hold;
	assign accept     = item_valid && !hold;

	fpdl_ctrl #(
		.MAX_INPUTS(MAX_INPUTS)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.operation    (operation),
		.element_index(element_index),
		.data_value   (data_value),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.mem_we       (mem_we),
		.mem_waddr    (mem_waddr),
		.mem_wdata    (mem_wdata),
		.mem_re       (mem_re),
		.mem_raddr    (mem_raddr),
		.tag          (tag)
	);

	fpdl_ram #(
		.WIDTH(DATA_W),
		.DEPTH(MAX_INPUTS)
	) u_store (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	fpdl_mac u_mac (
		.clk         (clk),
		.arst_n      (arst_n),
		.issue       (mem_re),
		.tag         (tag),
		.weight      (data_value),
		.bias        (bias_value),
		.rdata       ($signed(mem_rdata)),
		.result_stall(result_stall),
		.hold        (hold),
		.result_valid(result_valid),
		.neuron_value(neuron_value),
		.neuron_index(neuron_index),
		.last_neuron (last_neuron)
	);

endmodule

`default_nettype wire

FILE: rtl/fpdl_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module fpdl_checker import fpdl_pkg::*; (
	input wire logic                     clk,
	input wire logic                     arst_n,
	input wire logic                     item_stall,
	input wire logic                     result_valid,
	input wire logic                     result_stall,
	input wire logic signed [DATA_W-1:0] neuron_value,
	input wire logic [IDX_W-1:0]         neuron_index,
	input wire logic                     last_neuron
);

	logic [IDX_W-1:0] exp_idx_q;

	// Track the row number the next result must carry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_idx_q <= '0;
		end else if (result_valid && !result_stall) begin
			exp_idx_q <= last_neuron ? '0 : neuron_index + IDX_W'(1);
		end
	end

	// Stalled result holds its payload
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=>
			result_valid && $stable(neuron_value) && $stable(neuron_index)
			&& $stable(last_neuron))
		else $error("stalled result changed");

	// Rows are reported in order and wrap after the last one
	a_row_order: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> neuron_index == exp_idx_q)
		else $error("row index out of sequence");

	// Requests are only held off by a blocked result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> result_valid && result_stall)
		else $error("request stalled without a blocked result");

	// No result right after a reset edge
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |=> !result_valid)
		else $error("result shown during reset");

endmodule

bind fixed_point_dense_layer_core fpdl_checker u_fpdl_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.item_stall  (item_stall),
	.result_valid(result_valid),
	.result_stall(result_stall),
	.neuron_value(neuron_value),
	.neuron_index(neuron_index),
	.last_neuron (last_neuron)
);

`default_nettype wire

FILE: verif/tb_fixed_point_dense_layer_core.sv
`timescale 1ns / 1ps

module tb_fixed_point_dense_layer_core;
	import fpdl_pkg::*;

	localparam int QUIET_LIMIT     = 2000;
	localparam int SETTLE_CYCLES   = 8;
	localparam int DRAIN_CYCLES    = 10;
	localparam int TOTAL_REQUESTS  = 1950;
	localparam int LOG_LINES       = 64;

	typedef struct {
		logic signed [DATA_W-1:0] value;
		logic [IDX_W-1:0]         index;
		logic                     last;
	} neuron_t;

	// Tracks the layer state and the neurons still owed by the block
	class neuron_board;
		logic signed [DATA_W-1:0] elements [LEN_LIMIT];
		logic [IDX_W-1:0]  weight_pos;
		logic [IDX_W-1:0]  row_num;
		logic [DATA_W-1:0] row_sum;
		logic [CFG_W-1:0]  in_len;
		logic [CFG_W-1:0]  out_len;
		logic              relu_on;
		neuron_t           neurons_due[$];
		int                errors;

		function new();
			weight_pos = '0;
			row_num = '0;
			row_sum = '0;
			in_len = CFG_W'(1);
			out_len = CFG_W'(1);
			relu_on = 1'b0;
			errors = 0;
		endfunction

		// Saturate a length register into 1..LEN_LIMIT
		function int eff_len(logic [CFG_W-1:0] v);
			if (v == '0)
				return 1;
			if (v > LEN_LIMIT)
				return LEN_LIMIT;
			return int'(v);
		endfunction

		function int pending();
			return neurons_due.size();
		endfunction

		function void set_register(reg_idx_t which, logic [CFG_W-1:0] v);
			case (which)
				REG_INPUT_LEN: begin
					in_len = v;
				end
				REG_OUTPUT_LEN: begin
					out_len = v;
				end
				REG_RELU: begin
					relu_on = v[0];
				end
				default: begin
				end
			endcase
		endfunction

		// Apply one accepted request; a row's last weight owes one neuron
		function void note_request(op_t op, logic [IDX_W-1:0] idx,
				logic signed [DATA_W-1:0] data, logic signed [DATA_W-1:0] bias);
			int span, rows, pos, prod, scaled;
			logic [DATA_W-1:0] total;
			neuron_t n;
			if (op == OP_LOAD) begin
				elements[idx] = data;
				return;
			end
			span = eff_len(in_len);
			rows = eff_len(out_len);
			// a position past a shortened row reads the row's last element
			pos = (int'(weight_pos) < span) ? int'(weight_pos) : span - 1;
			prod = int'(elements[pos]) * int'(data);
			scaled = prod / (1 << Q_SHIFT);
			row_sum = row_sum + scaled[DATA_W-1:0];
			if (int'(weight_pos) + 1 < span) begin
				weight_pos = weight_pos + 1'b1;
				return;
			end
			total = row_sum + bias;
			if (relu_on && total[DATA_W-1])
				total = '0;
			n.value = total;
			n.index = row_num;
			n.last = (int'(row_num) + 1 >= rows);
			neurons_due.push_back(n);
			row_sum = '0;
			weight_pos = '0;
			row_num = n.last ? '0 : row_num + 1'b1;
		endfunction

		task flag_mismatch(string what);
			// keep the log short once things go badly wrong
			if (errors < LOG_LINES)
				$display("mismatch: %s", what);
			errors++;
		endtask

		task check_neuron(logic signed [DATA_W-1:0] value, logic [IDX_W-1:0] index,
				logic last);
			neuron_t n;
			if (neurons_due.size() == 0) begin
				flag_mismatch($sformatf("neuron %0d value %0d with none due", index, value));
				return;
			end
			n = neurons_due.pop_front();
			if (value !== n.value || index !== n.index || last !== n.last)
				flag_mismatch($sformatf("neuron got value %0d index %0d last %0b, want %0d %0d %0b",
					value, index, last, n.value, n.index, n.last));
		endtask
	endclass

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     item_valid = 1'b0;
	logic                     item_stall;
	logic                     operation = OP_LOAD;
	logic [IDX_W-1:0]         element_index = '0;
	logic signed [DATA_W-1:0] data_value = '0;
	logic signed [DATA_W-1:0] bias_value = '0;
	logic                     result_valid;
	logic                     result_stall = 1'b0;
	logic signed [DATA_W-1:0] neuron_value;
	logic [IDX_W-1:0]         neuron_index;
	logic                     last_neuron;
	logic                     cfg_we = 1'b0;
	logic [CIDX_W-1:0]        cfg_index = '0;
	logic [CFG_W-1:0]         cfg_data = '0;

	neuron_board board;
	bit          loaded [LEN_LIMIT];
	bit          send_tight = 1'b0;
	bit          recv_tight = 1'b0;
	int          requests_sent = 0;
	int          quiet_cycles = 0;

	fixed_point_dense_layer_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.operation(operation),
		.element_index(element_index),
		.data_value(data_value),
		.bias_value(bias_value),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.neuron_value(neuron_value),
		.neuron_index(neuron_index),
		.last_neuron(last_neuron),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Observe accepted requests, neurons and register writes
	always @(posedge clk) begin
		if (item_valid && !item_stall)
			board.note_request(op_t'(operation), element_index, data_value, bias_value);
		if (result_valid && !result_stall)
			board.check_neuron(neuron_value, neuron_index, last_neuron);
		if (cfg_we)
			board.set_register(reg_idx_t'(cfg_index), cfg_data);
	end

	// Abort when nothing moves for too long
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("tb_fixed_point_dense_layer_core: errors");
			$finish;
		end
	end

	// Hold off each neuron for a random number of cycles, or not at all when recv_tight is set
	initial begin
		int hold;
		wait (arst_n);
		@(posedge clk);
		forever begin
			hold = recv_tight ? 0 : $urandom_range(0, 15);
			if (hold > 0) begin
				result_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			result_stall <= 1'b0;
			@(posedge clk);
			while (!result_valid) @(posedge clk);
		end
	end

	function automatic logic [DATA_W-1:0] pick_word();
		case ($urandom_range(0, 3))
			0: begin
				return DATA_W'($urandom_range(0, 1023) - 512);
			end
			1: begin
				return $urandom_range(0, 1) ? {1'b0, {(DATA_W-1){1'b1}}}
					: {1'b1, {(DATA_W-1){1'b0}}};
			end
			default: begin
				return DATA_W'($urandom);
			end
		endcase
	endfunction

	// Present one request after a random gap, none when send_tight is set, and hold it until taken
	task automatic send_request(op_t op, logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data,
			logic [DATA_W-1:0] bias);
		int gap;
		gap = send_tight ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		operation <= op;
		element_index <= idx;
		data_value <= data;
		bias_value <= bias;
		if (op == OP_LOAD)
			loaded[idx] = 1'b1;
		requests_sent++;
		do @(posedge clk); while (item_stall);
	endtask

	task automatic load_element(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] value);
		send_request(OP_LOAD, idx, value, DATA_W'($urandom));
	endtask

	task automatic feed_weight(logic [DATA_W-1:0] weight, logic [DATA_W-1:0] bias);
		send_request(OP_WEIGHT, IDX_W'($urandom), weight, bias);
	endtask

	// Drop valid and let every owed neuron and any open work drain
	task automatic wait_idle();
		item_valid <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_layer(int in_len, int out_len, bit relu);
		cfg_we <= 1'b1;
		cfg_index <= REG_INPUT_LEN;
		cfg_data <= CFG_W'(in_len);
		@(posedge clk);
		cfg_index <= REG_OUTPUT_LEN;
		cfg_data <= CFG_W'(out_len);
		@(posedge clk);
		cfg_index <= REG_RELU;
		cfg_data <= CFG_W'(relu);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Configure, fill the span positions the weights reach, then stream rows plus a tail
	task automatic run_layer_phase(int in_len, int out_len, bit relu, int rows, int tail);
		int span, total, reach;
		logic [IDX_W-1:0] spot;
		wait_idle();
		set_layer(in_len, out_len, relu);
		span = board.eff_len(CFG_W'(in_len));
		total = rows * span + tail;
		// an open row continues from its current position
		reach = total + int'(board.weight_pos);
		for (int i = 0; i < span && i < reach; i++)
			if (!loaded[i])
				load_element(IDX_W'(i), pick_word());
		for (int k = 0; k < total; k++) begin
			// stray loads; at least half land inside the active span
			if ($urandom_range(0, 9) == 0) begin
				spot = $urandom_range(0, 1) ? IDX_W'($urandom_range(0, span - 1))
					: IDX_W'($urandom);
				load_element(spot, pick_word());
			end
			feed_weight(pick_word(), pick_word());
		end
	endtask

	initial begin
		int in_len, out_len, span, tail;
		board = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Extremes at reset lengths of one: every weight ends a row
		send_tight = $urandom_range(0, 1);
		load_element(0, 16'h7FFF);
		feed_weight(16'h7FFF, 16'h7FFF);
		load_element(0, 16'h8000);
		feed_weight(16'h8000, 16'h8000);
		// small negative products truncate toward zero
		load_element(0, -1);
		feed_weight(1, 0);
		feed_weight(255, 0);
		feed_weight(256, 0);
		feed_weight(-256, 0);
		load_element(0, 1);
		feed_weight(-257, 0);
		feed_weight(-1, 0);
		load_element(IDX_W'(LEN_LIMIT - 1), 16'h5A5A);
		load_element(IDX_W'(LEN_LIMIT / 2), 16'hA5A5);

		// ReLU clamps negatives, passes the rest
		wait_idle();
		set_layer(1, 1, 1'b1);
		load_element(0, -1000);
		feed_weight(256, 0);
		feed_weight(256, 2000);
		feed_weight(0, 16'h8000);
		feed_weight(0, 16'h7FFF);

		// zero lengths saturate to one
		wait_idle();
		set_layer(0, 0, 1'b0);
		feed_weight(256, -1);

		// Leave a row open, then shrink the row under it
		send_tight = 1'b0;
		run_layer_phase(8, 3, 1'b0, 1, 6);
		run_layer_phase(2, 3, 1'b1, 2, 0);
		// advance the row counter, then cut the row count below it
		run_layer_phase(4, 6, 1'b0, 4, 1);
		run_layer_phase(4, 2, 1'b1, 2, 0);
		// oversized lengths saturate to the maximum; the long row stays open
		// and the next one-weight layer closes it
		send_tight = 1'b1;
		run_layer_phase(2047, 1, 1'b0, 0, 40);
		run_layer_phase(1, 2047, 1'b1, LEN_LIMIT, 0);
		run_layer_phase(0, 0, 1'b1, 3, 0);

		// Random layers, mostly short rows
		while (requests_sent < TOTAL_REQUESTS) begin
			case ($urandom_range(0, 19))
				0: begin
					in_len = 0;
				end
				1: begin
					in_len = $urandom_range(17, 64);
				end
				default: begin
					in_len = $urandom_range(1, 12);
				end
			endcase
			case ($urandom_range(0, 19))
				0: begin
					out_len = 0;
				end
				1: begin
					out_len = $urandom_range(9, 40);
				end
				2: begin
					out_len = $urandom_range(LEN_LIMIT + 1, 2047);
				end
				default: begin
					out_len = $urandom_range(1, 8);
				end
			endcase
			span = board.eff_len(CFG_W'(in_len));
			tail = ($urandom_range(0, 2) == 0) ? $urandom_range(0, span - 1) : 0;
			send_tight = ($urandom_range(0, 4) == 0);
			recv_tight = ($urandom_range(0, 4) == 0);
			run_layer_phase(in_len, out_len, $urandom_range(0, 1), $urandom_range(1, 5), tail);
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.errors == 0)
			$display("tb_fixed_point_dense_layer_core: clean");
		else
			$display("tb_fixed_point_dense_layer_core: errors");
		$finish;
	end

endmodule
